/* sv/bsa_pkg.sv */
// bsa_pkg: shared constants, codes and types for the bitmap slot allocator
// no dependencies; imported by bsa_ctrl, bsa_dpath and bitmap_slot_allocator_core
package bsa_pkg;

  localparam int MAX_SLOT_COUNT = 1024;
  localparam int SLOT_W         = $clog2(MAX_SLOT_COUNT);
  localparam int CNT_W          = SLOT_W + 1;
  localparam int WORD_W         = 32;
  localparam int BIT_W          = $clog2(WORD_W);
  localparam int NWORDS         = MAX_SLOT_COUNT / WORD_W;
  localparam int WADDR_W        = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  localparam logic [CNT_W-1:0] NUM_SLOTS_RST = CNT_W'(MAX_SLOT_COUNT);
  localparam logic [CNT_W-1:0] MIN_SLOTS     = CNT_W'(2);

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_FULL         = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT     = 2'd2;
  localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] granted_slot;
    logic              has_spare;
    logic [CNT_W-1:0]  in_use_count;
  } rsp_t;

  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic       rd_scan;
    logic       mem_wr;
    logic       wr_set;
    logic       used_inc;
    logic       used_dec;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_grant;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       bad_slot;
    logic       dvld;
    logic       found;
    logic       last_word;
    logic       bit_set;
  } sts_t;

endpackage

/* sv/bsa_ctrl.sv */
// bsa_ctrl: request sequencer for the slot allocator (decode, word scan, free check)
// depends on bsa_pkg; drives bsa_dpath through cmd_t, reads sts_t
module bsa_ctrl import bsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  output logic rsp_valid,
  input  logic rsp_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_FREE_CHK = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       rsp_valid_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req_type)
          REQ_ALLOC: begin
            state_next = S_SCAN;
          end
          REQ_FREE: begin
            if (sts.bad_slot) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_BAD_SLOT;
              state_next     = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_FREE_CHK;
            end
          end
          default: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OK;
            state_next     = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_scan = 1'b1;
        if (sts.dvld) begin
          if (sts.found) begin
            cmd.mem_wr     = 1'b1;
            cmd.wr_set     = 1'b1;
            cmd.used_inc   = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_grant  = 1'b1;
            state_next     = S_DONE;
          end else if (sts.last_word) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_FULL;
            state_next     = S_DONE;
          end
        end
      end
      S_FREE_CHK: begin
        cmd.res_load = 1'b1;
        if (sts.bit_set) begin
          cmd.mem_wr     = 1'b1;
          cmd.used_dec   = 1'b1;
          cmd.res_status = ST_OK;
        end else begin
          cmd.res_status = ST_ALREADY_FREE;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_stall) begin
      rsp_valid_next = rsp_valid;
    end else begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("response raised outside the done state");

  a_scan_needs_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && sts.dvld && sts.found) |=> state == S_DONE)
    else $error("scan hit did not finish the request");

  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid)
    else $error("stalled response dropped");

endmodule

/* sv/bsa_dpath.sv */
// bsa_dpath: bitmap word memory, first-free search, in-use counter and result registers
// depends on bsa_pkg; controlled by bsa_ctrl through cmd_t
module bsa_dpath import bsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  req_t             req,
  input  cmd_t             cmd,
  output sts_t             sts,
  output rsp_t             rsp
);

  logic [WORD_W-1:0]  mem [NWORDS];
  logic [NWORDS-1:0]  row_vld;

  logic [CNT_W-1:0]   num_slots;
  logic [CNT_W-1:0]   eff_cnt;
  logic [1:0]         req_type_q;
  logic [SLOT_W-1:0]  idx_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [WADDR_W-1:0] wptr;
  logic [WADDR_W-1:0] cptr;
  logic               dvld;
  logic [WORD_W-1:0]  rdata_raw;
  logic               rd_row_vld;
  logic               rd_row0;
  logic [CNT_W-1:0]   used;
  logic [1:0]         res_status;
  logic [SLOT_W-1:0]  res_grant;

  logic [WADDR_W-1:0] rd_addr;
  logic [WADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0]  wdata;
  logic [WORD_W-1:0]  rdata;
  logic [SLOT_W-1:0]  cm1;
  logic [WADDR_W-1:0] last_w;
  logic [WORD_W-1:0]  free_bits;
  logic [BIT_W-1:0]   free_pos;
  logic [WORD_W-1:0]  set_mask;
  logic [WORD_W-1:0]  clr_mask;

  // saturate the slot count register into the legal range
  always_comb begin
    if (num_slots < MIN_SLOTS) begin
      eff_cnt = MIN_SLOTS;
    end else if (num_slots > NUM_SLOTS_RST) begin
      eff_cnt = NUM_SLOTS_RST;
    end else begin
      eff_cnt = num_slots;
    end
  end

  assign cm1     = SLOT_W'(cnt_q - CNT_W'(1));
  assign last_w  = cm1[SLOT_W-1:BIT_W];
  assign rd_addr = cmd.rd_scan ? wptr : idx_q[SLOT_W-1:BIT_W];
  assign wr_addr = cmd.wr_set ? cptr : idx_q[SLOT_W-1:BIT_W];
  assign rdata   = rd_row_vld ? rdata_raw : {{(WORD_W-1){1'b0}}, rd_row0};

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      free_bits[b] = ~rdata[b] & ((cptr < last_w) || (BIT_W'(b) <= cm1[BIT_W-1:0]));
    end
  end

  always_comb begin
    free_pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        free_pos = BIT_W'(b);
      end
    end
  end

  assign set_mask = {{(WORD_W-1){1'b0}}, 1'b1} << free_pos;
  assign clr_mask = {{(WORD_W-1){1'b0}}, 1'b1} << idx_q[BIT_W-1:0];
  assign wdata    = cmd.wr_set ? (rdata | set_mask) : (rdata & ~clr_mask);

  assign sts.req_type  = req_type_q;
  assign sts.bad_slot  = (idx_q == '0) || ({1'b0, idx_q} >= cnt_q);
  assign sts.dvld      = dvld;
  assign sts.found     = |free_bits;
  assign sts.last_word = (cptr == last_w);
  assign sts.bit_set   = rdata[idx_q[BIT_W-1:0]];

  // bitmap word memory
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_raw <= mem[rd_addr];
    end
    if (cmd.mem_wr) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld   <= '0;
      num_slots <= NUM_SLOTS_RST;
      used      <= CNT_W'(1);
      dvld      <= 1'b0;
    end else begin
      dvld <= cmd.rd_en;
      if (cmd.mem_wr) begin
        row_vld[wr_addr] <= 1'b1;
      end
      if (cfg_we) begin
        num_slots <= cfg_data;
      end
      if (cmd.used_inc) begin
        used <= used + CNT_W'(1);
      end else if (cmd.used_dec) begin
        used <= used - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type_q <= req.req_type;
      idx_q      <= req.slot_index;
      cnt_q      <= eff_cnt;
      wptr       <= '0;
    end else if (cmd.rd_en && cmd.rd_scan) begin
      wptr <= wptr + WADDR_W'(1);
    end
    if (cmd.rd_en) begin
      cptr       <= wptr;
      rd_row_vld <= row_vld[rd_addr];
      rd_row0    <= (rd_addr == '0);
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_grant  <= cmd.res_grant ? {cptr, free_pos} : '0;
    end
    if (cmd.load_out) begin
      rsp.status       <= res_status;
      rsp.granted_slot <= res_grant;
      rsp.has_spare    <= (used < cnt_q);
      rsp.in_use_count <= used;
    end
  end

  a_inc_on_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.used_inc |-> (dvld && sts.found && cmd.wr_set))
    else $error("in-use count raised without a free bit found");

  a_dec_step: assert property (@(posedge clk) disable iff (rst)
    cmd.used_dec |=> used == $past(used) - CNT_W'(1))
    else $error("in-use count did not drop by one on free");

  a_used_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> used != '0)
    else $error("in-use count lost the reserved slot");

endmodule

/* sv/bitmap_slot_allocator_core.sv */
// bitmap_slot_allocator_core: top level of the first-fit bitmap slot allocator
// depends on bsa_pkg, bsa_ctrl and bsa_dpath
//
// req channel (req_valid / req_stall, payload req): one request per transaction,
//   allocate, free or query. rsp channel (rsp_valid / rsp_stall, payload rsp):
//   exactly one response per request, in order.
// cfg channel (cfg_valid / cfg_ready, cfg_data): writes the slot count; cfg_ready
//   is always high. Write it only while no request is in flight.
// Sequence: a query or bad free goes from accept through decode to done, a good or
//   already-free free adds a check of the addressed word, and an allocate scans
//   from word 0 up to the 32-bit bitmap word holding the granted slot (or to the last
//   word in range when full). The scan reads one bitmap word per cycle from a word
//   memory with one read port and one write port.
// One request is in flight at a time; req_stall is low only when the sequencer
//   is idle. The response register lets the next request be accepted while a
//   response is still stalled; a finished result then waits until it drains.
// After the response is loaded the sequencer returns to idle, so the next request
//   can be taken in the cycle after the load.
// Reset: synchronous, active high. Slot 0 is marked allocated, all others free,
//   the in-use count is 1 and the slot count is 1024. Per-word valid bits stand
//   in for clearing the memory, so the block is ready right after reset.
module bitmap_slot_allocator_core import bsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsa_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .req      (req),
    .cmd      (cmd),
    .sts      (sts),
    .rsp      (rsp)
  );

endmodule

/* test/tb_bitmap_slot_allocator_core.sv */
`timescale 1ns / 100ps
// tb_bitmap_slot_allocator_core: self-checking testbench for the bitmap slot allocator
// predicts every response from its own bitmap copy and checks it field by field
// depends on bsa_pkg and bitmap_slot_allocator_core
module tb_bitmap_slot_allocator_core;
  import bsa_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         LIMIT_CYCLES = 900000;
  localparam int         MAX_REPORTS  = 40;

  logic             clk;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req_item  = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp_out;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;

  bit               slot_held [MAX_SLOT_COUNT];
  int unsigned      held_count;
  logic [CNT_W-1:0] slot_count_reg;
  rsp_t             pending_rsp_q[$];
  rsp_t             want_rsp;

  bit               tx_steady = 1'b0;
  bit               rx_steady = 1'b0;
  int               rx_hold   = 0;
  int unsigned      cycle_count = 0;
  bit               error_seen  = 1'b0;
  int               report_count = 0;

  bitmap_slot_allocator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      rsp_stall <= 1'b1;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      rx_hold   <= pick_gap() - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  function automatic int region_size();
    int n;
    n = int'(slot_count_reg);
    if (n < 2) n = 2;
    if (n > MAX_SLOT_COUNT) n = MAX_SLOT_COUNT;
    return n;
  endfunction

  function automatic rsp_t predict_response(req_t item);
    rsp_t o;
    int   n;
    int   s;
    n = region_size();
    o = '0;
    o.status = ST_OK;
    if (item.req_type == REQ_ALLOC) begin
      s = 1;
      while (s < n && slot_held[s]) s++;
      if (s >= n) begin
        o.status = ST_FULL;
      end else begin
        slot_held[s]   = 1'b1;
        held_count++;
        o.granted_slot = SLOT_W'(s);
      end
    end else if (item.req_type == REQ_FREE) begin
      s = int'(item.slot_index);
      if (s == 0 || s >= n) begin
        o.status = ST_BAD_SLOT;
      end else if (!slot_held[s]) begin
        o.status = ST_ALREADY_FREE;
      end else begin
        slot_held[s] = 1'b0;
        held_count--;
      end
    end
    o.has_spare    = (held_count < n);
    o.in_use_count = CNT_W'(held_count);
    return o;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      error_seen = 1'b1;
      if (report_count < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        report_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp_q.size() == 0) begin
        error_seen = 1'b1;
        if (report_count < MAX_REPORTS) begin
          $display("%0t: response with none expected, expected nothing actual %h",
                   $time, rsp_out);
          report_count++;
        end
      end else begin
        want_rsp = pending_rsp_q.pop_front();
        compare_field("status", 16'(want_rsp.status), 16'(rsp_out.status));
        compare_field("granted_slot", 16'(want_rsp.granted_slot),
                      16'(rsp_out.granted_slot));
        compare_field("has_spare", 16'(want_rsp.has_spare), 16'(rsp_out.has_spare));
        compare_field("in_use_count", 16'(want_rsp.in_use_count),
                      16'(rsp_out.in_use_count));
      end
    end
  end

  task automatic send_req(input req_t item);
    int gap;
    gap = 0;
    if (!tx_steady && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= item;
    do @(posedge clk); while (req_stall);
    pending_rsp_q.push_back(predict_response(item));
  endtask

  task automatic send_op(input logic [1:0] kind, input int idx);
    req_t item;
    item.req_type   = kind;
    item.slot_index = SLOT_W'(idx);
    send_req(item);
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    wait (pending_rsp_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [CNT_W-1:0] n);
    hold_until_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    slot_count_reg = n;
  endtask

  task automatic choose_pacing();
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
  endtask

  function automatic int held_slot_near(int start);
    int n;
    int s;
    n = region_size();
    for (int k = 0; k < n - 1; k++) begin
      s = 1 + (start - 1 + k) % (n - 1);
      if (slot_held[s]) return s;
    end
    return start;
  endfunction

  task automatic send_random_item(input int alloc_pct, input int free_pct);
    int r;
    int n;
    int idx;
    int sel;
    n   = region_size();
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, MAX_SLOT_COUNT - 1);
    if (r < alloc_pct) begin
      send_op(REQ_ALLOC, idx);
    end else if (r < alloc_pct + free_pct) begin
      sel = $urandom_range(0, 9);
      if (sel == 1) begin
        idx = n + $urandom_range(0, 7);
        if (idx > MAX_SLOT_COUNT - 1) idx = MAX_SLOT_COUNT - 1;
      end else if (sel == 2) begin
        idx = 0;
      end else if (sel != 0) begin
        idx = held_slot_near($urandom_range(1, n - 1));
      end
      send_op(REQ_FREE, idx);
    end else begin
      send_op($urandom_range(0, 1) ? REQ_QUERY : REQ_UNUSED, idx);
    end
    if ($urandom_range(0, 199) == 0) hold_until_drained();
  endtask

  task automatic random_mix(input int n_items, input int alloc_pct, input int free_pct);
    choose_pacing();
    repeat (n_items) send_random_item(alloc_pct, free_pct);
  endtask

  task automatic test_reset_and_edges();
    send_op(REQ_QUERY, 0);
    send_op(REQ_UNUSED, 1023);
    send_op(REQ_FREE, 0);
    send_op(REQ_FREE, 1023);
    send_op(REQ_FREE, 1);
    send_op(REQ_ALLOC, 1023);
    send_op(REQ_ALLOC, 0);
    send_op(REQ_ALLOC, 0);
    send_op(REQ_FREE, 2);
    send_op(REQ_ALLOC, 682);
    write_slot_count(11'd4);
    send_op(REQ_ALLOC, 0);
    send_op(REQ_FREE, 3);
    send_op(REQ_FREE, 3);
    send_op(REQ_ALLOC, 341);
    write_slot_count(11'd2);
    send_op(REQ_FREE, 2);
    send_op(REQ_ALLOC, 0);
    send_op(REQ_FREE, 1);
    send_op(REQ_ALLOC, 0);
    write_slot_count(11'd0);
    send_op(REQ_ALLOC, 0);
    write_slot_count(11'd2047);
    send_op(REQ_FREE, 3);
    send_op(REQ_FREE, 2);
    send_op(REQ_FREE, 1);
  endtask

  task automatic test_count_saturation();
    logic [CNT_W-1:0] counts [4];
    counts = '{11'd0, 11'd1, 11'd1025, 11'd2047};
    foreach (counts[i]) begin
      write_slot_count(counts[i]);
      send_op(REQ_ALLOC, $urandom_range(0, 1023));
      send_op(REQ_ALLOC, $urandom_range(0, 1023));
      send_op(REQ_QUERY, $urandom_range(0, 1023));
    end
  endtask

  task automatic test_small_regions();
    write_slot_count(11'd3);
    random_mix(45, 50, 40);
    repeat (7) begin
      write_slot_count(CNT_W'($urandom_range(2, 48)));
      random_mix(45, 50, 40);
    end
  endtask

  task automatic test_shrink_with_held();
    write_slot_count(11'd64);
    random_mix(70, 75, 15);
    write_slot_count(11'd8);
    random_mix(60, 40, 50);
    write_slot_count(11'd64);
    random_mix(40, 40, 50);
  endtask

  task automatic test_mid_regions();
    repeat (2) begin
      write_slot_count(CNT_W'($urandom_range(100, 700)));
      random_mix(60, 60, 30);
    end
  endtask

  task automatic test_fill_region();
    write_slot_count(11'd1024);
    choose_pacing();
    while (held_count < MAX_SLOT_COUNT) send_random_item(93, 4);
    repeat (3) send_op(REQ_ALLOC, $urandom_range(0, 1023));
    random_mix(80, 35, 55);
    write_slot_count(11'd2);
    random_mix(10, 40, 50);
    write_slot_count(11'd1024);
    random_mix(20, 50, 40);
  endtask

  initial begin
    foreach (slot_held[i]) slot_held[i] = 1'b0;
    slot_held[0]   = 1'b1;
    held_count     = 1;
    slot_count_reg = NUM_SLOTS_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_and_edges();
    test_count_saturation();
    test_small_regions();
    test_shrink_with_held();
    test_mid_regions();
    test_fill_region();

    hold_until_drained();
    repeat (40) @(posedge clk);
    if (!error_seen && pending_rsp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/bsa_pkg.sv
sv/bsa_ctrl.sv
sv/bsa_dpath.sv
sv/bitmap_slot_allocator_core.sv
test/tb_bitmap_slot_allocator_core.sv
